FILE: sv/tks_pkg.sv
// Package for the two-key record sorter: item types, cell control and the
// ranking function. No dependencies.
`default_nettype none
package tks_pkg;

  localparam int unsigned IdW    = 32;
  localparam int unsigned ScoreW = 11;
  localparam int unsigned PenW   = 16;

  localparam logic [ScoreW-1:0] ScoreMax = ScoreW'(2000);

  typedef struct packed {
    logic [IdW-1:0]    record_id;
    logic [ScoreW-1:0] score;
    logic [PenW-1:0]   penalties;
    logic              last_record;
  } in_item_t;

  typedef struct packed {
    logic [IdW-1:0]    out_id;
    logic [ScoreW-1:0] out_score;
    logic [PenW-1:0]   out_penalties;
    logic              final_result;
    logic              records_dropped;
  } out_item_t;

  // One stored record as held in a cell.
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [ScoreW-1:0] score;
    logic [PenW-1:0]   pen;
  } rec_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast record, shift the tail down
    logic shift;   // move every record one cell towards the head
  } cell_ctrl_t;

  // True when record a must come strictly before record b.
  function automatic logic ranks_before(rec_t a, rec_t b);
    logic r;
    if (a.score != b.score) begin
      r = (a.score > b.score);
    end else begin
      r = (a.pen < b.pen);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/two_key_record_sorter_unit.sv
// Two-key record sorter: a chain of insertion cells sorting records on load.
// Depends on tks_pkg and tks_cell.
// Throughput: one item per cycle while loading, each placed at its accepting
//   edge; the held batch then drains from the head cell with busy_o high.
// Latency: first result in the cycle after the last_record item; no stalls.
// Reset: asynchronous, active low; clears count, drop flag and state, not cells.
`default_nettype none
module two_key_record_sorter_unit
  import tks_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start_i,
  input  in_item_t  in_item_i,
  output logic      busy_o,
  output logic      result_valid_o,
  output out_item_t out_item_o
);

  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  // Load or drain: localparam codes on a plain vector.
  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dropped_q, dropped_d;

  logic       accept;
  logic       full;
  rec_t       new_rec;
  cell_ctrl_t ctrl;

  rec_t cell_rec [MAX_RECORDS];
  logic cell_ins [MAX_RECORDS];

  assign accept = start_i && (state_q == StLoad);
  assign full   = (count_q == CntW'(MAX_RECORDS));

  // Saturate the score into range before it enters the chain.
  always_comb begin
    new_rec.id    = in_item_i.record_id;
    new_rec.score = (in_item_i.score > ScoreMax) ? ScoreMax : in_item_i.score;
    new_rec.pen   = in_item_i.penalties;
  end

  assign ctrl.insert = accept && !full;
  assign ctrl.shift  = (state_q == StDrain);

  // Build the chain; occupied cells always form a prefix of count_q cells.
  for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
    logic occupied;
    logic prev_ins;
    rec_t prev_rec;
    rec_t next_rec;

    assign occupied = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign prev_ins = 1'b0;
      assign prev_rec = new_rec;
    end else begin : g_body
      assign prev_ins = cell_ins[i-1];
      assign prev_rec = cell_rec[i-1];
    end

    if (i == MAX_RECORDS - 1) begin : g_tail
      assign next_rec = cell_rec[i];
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
    end

    tks_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_rec_i  (new_rec),
      .occupied_i (occupied),
      .prev_ins_i (prev_ins),
      .prev_rec_i (prev_rec),
      .next_rec_i (next_rec),
      .ins_o      (cell_ins[i]),
      .rec_o      (cell_rec[i])
    );
  end

  // Sequencing: count records in, note drops, then drain from the head.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    case (state_q)
      StLoad: begin
        if (accept) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (in_item_i.last_record) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          // Last result goes out this cycle: clear for the next batch.
          state_d   = StLoad;
          dropped_d = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StLoad;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
    end
  end

  // Results come straight from the head cell's register.
  assign busy_o         = (state_q == StDrain);
  assign result_valid_o = (state_q == StDrain);

  always_comb begin
    out_item_o.out_id          = cell_rec[0].id;
    out_item_o.out_score       = cell_rec[0].score;
    out_item_o.out_penalties   = cell_rec[0].pen;
    out_item_o.final_result    = (count_q == CntW'(1));
    out_item_o.records_dropped = dropped_q;
  end

  // A batch end always produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_record) |=> result_valid_o)
    else $error("no result after batch end");

  // Results run without gaps until the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !out_item_o.final_result) |=> result_valid_o)
    else $error("gap in result stream");

  // After the final result the block is ready with an empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_item_o.final_result) |=>
      (!busy_o && count_q == '0 && !dropped_q))
    else $error("block not cleared after final result");

  // The count never exceeds the store size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_RECORDS))
    else $error("record count out of range");

  // Draining never starts from an empty store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (count_q != '0))
    else $error("drain with empty store");

endmodule
`default_nettype wire

FILE: sv/tks_cell.sv
// One cell of the insertion chain: holds one record and decides whether the
// broadcast record lands here. Depends on tks_pkg.
`default_nettype none
module tks_cell
  import tks_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_rec_i,
  input  logic       occupied_i,
  input  logic       prev_ins_i,
  input  rec_t       prev_rec_i,
  input  rec_t       next_rec_i,
  output logic       ins_o,
  output rec_t       rec_o
);

  rec_t rec_q, rec_d;

  // An empty cell always takes part; ties stay behind the held record.
  assign ins_o = !occupied_i || ranks_before(new_rec_i, rec_q);

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.insert && ins_o) begin
      rec_d = prev_ins_i ? prev_rec_i : new_rec_i;
    end else if (ctrl_i.shift) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
`default_nettype wire

FILE: tb/tb_two_key_record_sorter_unit.sv
// Self-checking testbench for two_key_record_sorter_unit: directed batches, then
// random batches checked against a behavioural sorter. Depends on tks_pkg and the RTL.
`default_nettype none
module tb_two_key_record_sorter_unit
  import tks_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = 64;
  localparam int unsigned TimeoutNs  = 400000;
  localparam int unsigned MaxIdle    = 20;

  // One row of the directed table. Rows marked fixed are single-record
  // batches whose only result is typed in beside the record.
  typedef struct {
    in_item_t  rec;
    logic      fixed;
    out_item_t res;
  } stim_row_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      start_i   = 1'b0;
  in_item_t  in_item_i = '0;
  logic      busy_o;
  logic      result_valid_o;
  out_item_t out_item_o;

  // Behavioural copy of the block: the batch held in ranked order, the drop
  // flag, and the results still owed by the block.
  rec_t        ranked_batch[$];
  logic        batch_dropped = 1'b0;
  out_item_t   owed_results[$];
  out_item_t   head_result;
  stim_row_t   directed_rows[$];
  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;

  two_key_record_sorter_unit #(
    .MAX_RECORDS (StoreDepth)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_item_i      (in_item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .out_item_o     (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sorting predictor
  // ---------------------------------------------------------------------------

  // Higher score wins; on equal score the smaller penalty count wins. Equal
  // keys do not outrank, which is what keeps ties in load order.
  function automatic logic outranks(rec_t a, rec_t b);
    if (a.score != b.score) begin
      return a.score > b.score;
    end
    return a.pen < b.pen;
  endfunction

  // Place one accepted item in the held batch. Clamp the score at full scale,
  // drop the record if the store is already full, and on the final record
  // release the whole batch as owed results and clear for the next batch.
  task automatic rank_record(input in_item_t item);
    rec_t        r;
    out_item_t   o;
    int unsigned pos;
    r.id    = item.record_id;
    r.score = (item.score > ScoreMax) ? ScoreMax : item.score;
    r.pen   = item.penalties;
    if (ranked_batch.size() < StoreDepth) begin
      pos = ranked_batch.size();
      // walk up past every held record that the new one outranks
      while (pos > 0 && outranks(r, ranked_batch[pos-1])) begin
        pos--;
      end
      ranked_batch.insert(pos, r);
    end else begin
      batch_dropped = 1'b1;
    end
    if (item.last_record) begin
      foreach (ranked_batch[k]) begin
        o.out_id          = ranked_batch[k].id;
        o.out_score       = ranked_batch[k].score;
        o.out_penalties   = ranked_batch[k].pen;
        o.final_result    = (k == ranked_batch.size() - 1);
        o.records_dropped = batch_dropped;
        owed_results.push_back(o);
      end
      ranked_batch.delete();
      batch_dropped = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [IdW-1:0] want,
                                      logic [IdW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Each strobed result is taken at the edge that ends its cycle and matched
  // against the oldest owed result.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0h", $time, out_item_o);
        mismatch_count++;
      end else begin
        head_result = owed_results.pop_front();
        check_field("out_id", head_result.out_id, out_item_o.out_id);
        check_field("out_score", IdW'(head_result.out_score), IdW'(out_item_o.out_score));
        check_field("out_penalties", IdW'(head_result.out_penalties),
                    IdW'(out_item_o.out_penalties));
        check_field("final_result", IdW'(head_result.final_result),
                    IdW'(out_item_o.final_result));
        check_field("records_dropped", IdW'(head_result.records_dropped),
                    IdW'(out_item_o.records_dropped));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic stim_row_t plain_row(logic [IdW-1:0] id, logic [ScoreW-1:0] sc,
                                          logic [PenW-1:0] pen, logic last);
    stim_row_t row;
    row.rec   = '{record_id: id, score: sc, penalties: pen, last_record: last};
    row.fixed = 1'b0;
    row.res   = '0;
    return row;
  endfunction

  // A batch of one record: its only result is the record itself, flagged
  // final, never dropped, with the score as the block should show it.
  function automatic stim_row_t lone_row(logic [IdW-1:0] id, logic [ScoreW-1:0] sc,
                                         logic [PenW-1:0] pen, logic [ScoreW-1:0] shown);
    stim_row_t row;
    row       = plain_row(id, sc, pen, 1'b1);
    row.fixed = 1'b1;
    row.res   = '{out_id: id, out_score: shown, out_penalties: pen,
                  final_result: 1'b1, records_dropped: 1'b0};
    return row;
  endfunction

  // Random record. Scores bunch on a few values, including ones above full
  // scale, so that ties on one or both keys turn up often.
  function automatic in_item_t random_record(logic last);
    in_item_t    item;
    int unsigned hot [4] = '{0, 1000, 1999, 2000};
    item.record_id = $urandom;
    case ($urandom_range(3))
      0:       item.score = ScoreW'($urandom_range(2047));
      1:       item.score = ScoreW'(hot[$urandom_range(3)]);
      2:       item.score = ScoreW'($urandom_range(2047, 2001));
      default: item.score = ScoreW'($urandom_range(502, 500));
    endcase
    item.penalties   = $urandom_range(1) ? PenW'($urandom_range(3))
                                         : PenW'($urandom_range(65535));
    item.last_record = last;
    return item;
  endfunction

  // Offer one item and hold it until the block takes it. Called at a rising
  // edge; returns at a rising edge with start_i set up for the caller.
  task automatic send_record(input in_item_t rec, input logic fixed, input out_item_t res);
    int unsigned idle_cycles;
    start_i   <= 1'b1;
    in_item_i <= rec;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (fixed) begin
      owed_results.push_back(res);
    end else begin
      rank_record(rec);
    end
    // idle the sender for a random stretch, with noise on the item bus
    idle_cycles = 0;
    while (idle_cycles < MaxIdle && $urandom_range(99) < idle_pct) begin
      idle_cycles++;
    end
    if (idle_cycles != 0) begin
      start_i   <= 1'b0;
      in_item_i <= random_record($urandom_range(1));
      repeat (idle_cycles) @(posedge clk_i);
    end
  endtask

  task automatic send_batch(input int unsigned size);
    for (int unsigned k = 0; k < size; k++) begin
      send_record(random_record(k == size - 1), 1'b0, '0);
    end
  endtask

  // One random phase: an optional large batch, then short batches until the
  // item budget is spent.
  task automatic run_phase(input int unsigned pct, input int unsigned big_size,
                           input int unsigned budget);
    int unsigned sent;
    int unsigned size;
    idle_pct = pct;
    sent     = big_size;
    if (big_size != 0) begin
      send_batch(big_size);
    end
    while (sent < budget) begin
      size = $urandom_range(8, 1);
      send_batch(size);
      sent += size;
    end
  endtask

  initial begin
    // single-record batches at the field extremes and across the clamp
    directed_rows.push_back(lone_row(32'h0000_0000, 11'd0, 16'h0000, 11'd0));
    directed_rows.push_back(lone_row(32'hFFFF_FFFF, 11'd2000, 16'hFFFF, 11'd2000));
    directed_rows.push_back(lone_row(32'hA5A5_5A5A, 11'd2047, 16'h1234, 11'd2000));
    directed_rows.push_back(lone_row(32'h0000_0001, 11'd2001, 16'h0000, 11'd2000));
    directed_rows.push_back(lone_row(32'h0000_0002, 11'd1999, 16'h0007, 11'd1999));
    // mixed batch: full ties keep load order, penalties break score ties,
    // and a clamped score ties with an exact full-scale one
    directed_rows.push_back(plain_row(32'd10, 11'd500, 16'd3, 1'b0));
    directed_rows.push_back(plain_row(32'd11, 11'd500, 16'd3, 1'b0));
    directed_rows.push_back(plain_row(32'd12, 11'd500, 16'd1, 1'b0));
    directed_rows.push_back(plain_row(32'd13, 11'd700, 16'd9, 1'b0));
    directed_rows.push_back(plain_row(32'd14, 11'd2047, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(32'd15, 11'd2000, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(32'd16, 11'd0, 16'd65535, 1'b0));
    directed_rows.push_back(plain_row(32'd17, 11'd500, 16'd3, 1'b1));
    // batch arriving already in order
    directed_rows.push_back(plain_row(32'd20, 11'd2000, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(32'd21, 11'd1000, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(32'd22, 11'd1000, 16'd1, 1'b0));
    directed_rows.push_back(plain_row(32'd23, 11'd0, 16'd65535, 1'b1));
    // batch arriving in reverse order: every record travels to the head
    directed_rows.push_back(plain_row(32'd30, 11'd0, 16'd65535, 1'b0));
    directed_rows.push_back(plain_row(32'd31, 11'd0, 16'd65534, 1'b0));
    directed_rows.push_back(plain_row(32'd32, 11'd1, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(32'd33, 11'd2000, 16'd65535, 1'b0));
    directed_rows.push_back(plain_row(32'd34, 11'd2000, 16'd0, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 31;
    foreach (directed_rows[i]) begin
      send_record(directed_rows[i].rec, directed_rows[i].fixed, directed_rows[i].res);
    end

    // sender idles often: exactly a full store
    run_phase(31, StoreDepth, 64);
    // sender idles more: an overlong batch, so the final record is dropped too
    run_phase(55, StoreDepth + $urandom_range(3, 1), 70);
    // back to back
    run_phase(0, 0, 16);

    start_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    // allow a stray extra result to show up before the verdict
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[two_key_record_sorter_unit] OK");
    end else begin
      $display("[two_key_record_sorter_unit] ERROR");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #TimeoutNs;
    $display("[two_key_record_sorter_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
